// ----- rtl/core/jddm_pkg.sv -----
// Shared types and constants for the joystick differential drive mixer.
// Holds field widths, register indexes, d-pad codes and the multiplier control bundle.
// No dependencies.
package jddm_pkg;

    // Fraction bits of the axis values, commands and duties
    localparam int FRAC_BITS = 8;

    // Fixed widths of the report and result fields
    localparam int STICK_W = 11;
    localparam int DPAD_W  = 4;
    localparam int PCT_W   = 7;
    localparam int STEP_W  = 6;
    localparam int DUTY_W  = FRAC_BITS + 7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_STEP = 2'd2;

    // Register reset values
    localparam logic [PCT_W-1:0]  DEADBAND_RST    = 7'd10;
    localparam logic [PCT_W-1:0]  DRIVE_LIMIT_RST = 7'd85;
    localparam logic [STEP_W-1:0] BAL_STEP_RST    = 6'd5;

    // D-pad direction bits
    localparam logic [DPAD_W-1:0] HAT_UP    = 4'd1;
    localparam logic [DPAD_W-1:0] HAT_DOWN  = 4'd2;
    localparam logic [DPAD_W-1:0] HAT_RIGHT = 4'd4;
    localparam logic [DPAD_W-1:0] HAT_LEFT  = 4'd8;

    // Balance and percent constants
    localparam int BAL_CENTER = 50;
    localparam int BAL_MAX    = 100;
    localparam int PCT_FULL   = 100;
    localparam int DUTY_RND   = 50;   // half of the percent divisor
    localparam int AXIS_SHIFT = 18;   // 512 * 512 full-scale square

    // Control bundle for the shared multiplier
    typedef struct packed {
        logic load;      // capture a new product
        logic add_rnd;   // add the half-percent rounding term
    } mul_ctl_t;

endpackage

// ----- rtl/core/jddm_mul.sv -----
// Shared multiply unit with a registered product and optional rounding addend.
// Depends on jddm_pkg for the control bundle and the rounding constant.
module jddm_mul
    import jddm_pkg::*;
#(
    parameter int A_W = 22,
    parameter int B_W = 16
) (
    input  logic               aclk,
    input  mul_ctl_t           ctl,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] prod
);

    localparam int P_W = A_W + B_W;

    logic [P_W-1:0] prod_reg;
    logic [P_W-1:0] prod_next;

    // Form product plus optional rounding term
    always_comb begin
        prod_next = P_W'(a) * P_W'(b) + (ctl.add_rnd ? P_W'(DUTY_RND) : '0);
    end

    // Hold product until the sequencer loads the next one
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/joystick_differential_drive_mixer.sv -----
// Top level of the joystick differential drive mixer: sequencer, state and output register.
// Depends on jddm_pkg and instantiates jddm_mul as the one shared multiplier.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      four stick axes, d-pad, home
//   m_        out        m_valid / m_ready      direction pins, duties, balance
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// After its transfer a report occupies the sequencer from ST_SQX to ST_DONE, with s_ready low
// until ST_IDLE; all multiplies go through one shared multiplier, at most one per cycle.
// The result sits in an output register, so a new report is taken while it waits.
// A stalled m_ready holds the sequencer in its last step once the next result is ready.
// Reset (aresetn low, synchronous) restores the settings, centres the balance, clears m_valid.
// cfg_ready is always high; a write is registered at the clock edge that accepts it.
module joystick_differential_drive_mixer
    import jddm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    // report channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [STICK_W-1:0]   s_left_stick_x,
    input  logic signed [STICK_W-1:0]   s_left_stick_y,
    input  logic signed [STICK_W-1:0]   s_right_stick_x,
    input  logic signed [STICK_W-1:0]   s_right_stick_y,
    input  logic [DPAD_W-1:0]           s_dpad_bits,
    input  logic                        s_home_pressed,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_right_forward,
    output logic                        m_right_reverse,
    output logic [DUTY_W-1:0]           m_right_duty,
    output logic                        m_left_forward,
    output logic                        m_left_reverse,
    output logic [DUTY_W-1:0]           m_left_duty,
    output logic [PCT_W-1:0]            m_balance_now,
    // configuration channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [PCT_W-1:0]            cfg_wdata
);

    localparam int FB   = FRAC_BITS;
    localparam int SQW  = 2 * STICK_W - 1;   // magnitude never exceeds 1024
    localparam int RAWW = SQW + PCT_W;       // square times drive limit
    localparam int QW   = FB + 10;           // rounded axis magnitude
    localparam int SW   = QW + 1;            // signed axis value
    localparam int SUMW = SW + 1;            // axis sum or difference
    localparam int CW   = FB + 8;            // clamped command, signed
    localparam int MGW  = FB + 7;            // command magnitude
    localparam int NW   = FB + 14;           // duty dividend
    localparam int MW   = NW - 6;            // reciprocal and quotient
    localparam int MA   = (NW > SQW) ? NW : SQW;
    localparam int MB   = MW;
    localparam int PW   = MA + MB;
    localparam int LIM  = PCT_FULL << FB;

    localparam logic [MW-1:0] RECIP = MW'((64'd1 << NW) / 64'(PCT_FULL));
    localparam logic [RAWW+FB:0] RND_HALF = (RAWW + FB + 1)'(1) << (AXIS_SHIFT - 1);
    localparam logic signed [SUMW-1:0] LIM_S = SUMW'(LIM);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_DLX, ST_AXX, ST_DLY, ST_AXY, ST_MIX,
        ST_RMUL, ST_RDIV, ST_RFIX, ST_LDIV, ST_LFIX, ST_DONE
    } state_t;

    state_t                   state_reg;
    logic [PCT_W-1:0]         deadband_reg;
    logic [PCT_W-1:0]         drive_limit_reg;
    logic [STEP_W-1:0]        balance_step_reg;
    logic [PCT_W-1:0]         balance_reg;
    logic [PCT_W-1:0]         balance_next;
    logic                     latch_reg;
    logic                     latch_next;
    logic [STICK_W-1:0]       ax_reg;
    logic [STICK_W-1:0]       ay_reg;
    logic                     xneg_reg;
    logic                     yneg_reg;
    logic [DPAD_W-1:0]        dpad_reg;
    logic [QW-1:0]            xq_reg;
    logic                     xdb_reg;
    logic signed [SW-1:0]     xv_reg;
    logic signed [SW-1:0]     yv_reg;
    logic signed [CW-1:0]     rcmd_reg;
    logic signed [CW-1:0]     lcmd_reg;
    logic [NW-1:0]            n_reg;
    logic [DUTY_W-1:0]        rduty_reg;
    logic [DUTY_W-1:0]        lduty_reg;
    logic                     m_valid_reg;
    logic                     m_right_forward_reg;
    logic                     m_right_reverse_reg;
    logic [DUTY_W-1:0]        m_right_duty_reg;
    logic                     m_left_forward_reg;
    logic                     m_left_reverse_reg;
    logic [DUTY_W-1:0]        m_left_duty_reg;
    logic [PCT_W-1:0]         m_balance_now_reg;

    // Combinational helpers
    logic [STICK_W-1:0]       lx_mag, ly_mag, rx_mag, ry_mag;
    logic signed [STICK_W-1:0] sx, sy;
    logic [PCT_W:0]           bal_sum;
    logic [RAWW-1:0]          raw;
    logic [RAWW+FB:0]         rnd;
    logic [QW-1:0]            q_cur;
    logic                     db_cur;
    logic [RAWW-1:0]          thr;
    logic signed [SW-1:0]     xv_comb, yv_comb, full_s;
    logic signed [SUMW-1:0]   rsum, lsum;
    logic [PCT_W-1:0]         lnum, rnum;
    logic [MGW-1:0]           rmag, lmag;
    logic [MW-1:0]            q_est, duty_full, duty_chk;
    logic [NW-1:0]            rem;
    logic [DUTY_W-1:0]        duty_out;
    mul_ctl_t                 mul_ctl;
    logic [MA-1:0]            mul_a;
    logic [MB-1:0]            mul_b;
    logic [PW-1:0]            prod_q;

    function automatic logic [STICK_W-1:0] stick_mag(input logic signed [STICK_W-1:0] v);
        return v[STICK_W-1] ? STICK_W'(-v) : STICK_W'(v);
    endfunction

    function automatic logic signed [CW-1:0] clamp_cmd(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] c;
        c = v;
        if (v > LIM_S) begin
            c = LIM_S;
        end else if (v < -LIM_S) begin
            c = -LIM_S;
        end
        return CW'(c);
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Pick the stronger stick per axis; a tie keeps the right stick
    assign lx_mag = stick_mag(s_left_stick_x);
    assign ly_mag = stick_mag(s_left_stick_y);
    assign rx_mag = stick_mag(s_right_stick_x);
    assign ry_mag = stick_mag(s_right_stick_y);
    assign sx     = (lx_mag > rx_mag) ? s_left_stick_x : s_right_stick_x;
    assign sy     = (ly_mag > ry_mag) ? s_left_stick_y : s_right_stick_y;

    // Balance trim and press latch for the report being taken
    assign bal_sum = {1'b0, balance_reg} + (PCT_W + 1)'(balance_step_reg);

    always_comb begin
        balance_next = balance_reg;
        latch_next   = latch_reg;
        if (s_dpad_bits == HAT_LEFT && s_home_pressed && !latch_reg
                && balance_reg != '0) begin
            balance_next = (balance_reg > PCT_W'(balance_step_reg))
                         ? balance_reg - PCT_W'(balance_step_reg) : '0;
            latch_next   = 1'b1;
        end
        if (s_dpad_bits == HAT_RIGHT && s_home_pressed && !latch_reg
                && balance_reg < PCT_W'(BAL_MAX)) begin
            balance_next = (bal_sum > (PCT_W + 1)'(BAL_MAX))
                         ? PCT_W'(BAL_MAX) : PCT_W'(bal_sum);
            latch_next   = 1'b1;
        end
        if ((s_dpad_bits == HAT_UP || s_dpad_bits == HAT_DOWN) && s_home_pressed) begin
            balance_next = PCT_W'(BAL_CENTER);
        end
        if (s_dpad_bits != HAT_RIGHT && s_dpad_bits != HAT_LEFT) begin
            latch_next = 1'b0;
        end
    end

    // Round the scaled square to Q(FB) and test it against the deadband
    assign raw    = prod_q[RAWW-1:0];
    assign rnd    = {1'b0, raw, {FB{1'b0}}} + RND_HALF;
    assign q_cur  = rnd[AXIS_SHIFT +: QW];
    assign thr    = RAWW'({deadband_reg, {AXIS_SHIFT{1'b0}}});
    assign db_cur = (raw < thr);

    // Apply sign inversion, joint deadband and d-pad overrides
    assign full_s = $signed(SW'({drive_limit_reg, {FB{1'b0}}}));

    always_comb begin
        xv_comb = xneg_reg ? -$signed({1'b0, xq_reg}) : $signed({1'b0, xq_reg});
        yv_comb = yneg_reg ? -$signed({1'b0, q_cur}) : $signed({1'b0, q_cur});
        if (xdb_reg && db_cur) begin
            xv_comb = '0;
            yv_comb = '0;
        end
        if (dpad_reg inside {HAT_UP, HAT_UP | HAT_RIGHT, HAT_UP | HAT_LEFT}) begin
            yv_comb = full_s;
        end
        if (dpad_reg inside {HAT_RIGHT, HAT_UP | HAT_RIGHT, HAT_DOWN | HAT_RIGHT}) begin
            xv_comb = -full_s;
        end
        if (dpad_reg inside {HAT_DOWN, HAT_DOWN | HAT_RIGHT, HAT_DOWN | HAT_LEFT}) begin
            yv_comb = -full_s;
        end
        if (dpad_reg inside {HAT_LEFT, HAT_UP | HAT_LEFT, HAT_RIGHT | HAT_LEFT}) begin
            xv_comb = full_s;
        end
    end

    // Mix: right is y + x, left is y - x
    assign rsum = SUMW'(yv_reg) + SUMW'(xv_reg);
    assign lsum = SUMW'(yv_reg) - SUMW'(xv_reg);

    // Balance multipliers in percent
    assign lnum = (balance_reg < PCT_W'(BAL_CENTER))
                ? PCT_W'(BAL_CENTER) + balance_reg : PCT_W'(PCT_FULL);
    assign rnum = (balance_reg > PCT_W'(BAL_CENTER))
                ? PCT_W'((PCT_W + 1)'(PCT_FULL + BAL_CENTER) - {1'b0, balance_reg})
                : PCT_W'(PCT_FULL);

    assign rmag = rcmd_reg[CW-1] ? MGW'(-rcmd_reg) : MGW'(rcmd_reg);
    assign lmag = lcmd_reg[CW-1] ? MGW'(-lcmd_reg) : MGW'(lcmd_reg);

    // Divide by 100 via reciprocal plus one remainder fix; zero any duty above the limit
    assign q_est     = prod_q[NW +: MW];
    assign rem       = n_reg - NW'(q_est) * NW'(PCT_FULL);
    assign duty_full = q_est + MW'(rem >= NW'(PCT_FULL));
    assign duty_chk  = (duty_full > MW'(LIM)) ? '0 : duty_full;
    assign duty_out  = DUTY_W'(duty_chk);

    // Steer the shared multiplier by sequencer step
    always_comb begin
        mul_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            ST_SQX: begin
                mul_ctl.load = 1'b1;
                mul_a        = MA'(ax_reg);
                mul_b        = MB'(ax_reg);
            end
            ST_DLX, ST_DLY: begin
                mul_ctl.load = 1'b1;
                mul_a        = MA'(prod_q[SQW-1:0]);
                mul_b        = MB'(drive_limit_reg);
            end
            ST_AXX: begin
                mul_ctl.load = 1'b1;
                mul_a        = MA'(ay_reg);
                mul_b        = MB'(ay_reg);
            end
            ST_RMUL: begin
                mul_ctl.load    = 1'b1;
                mul_ctl.add_rnd = 1'b1;
                mul_a           = MA'(rmag);
                mul_b           = MB'(rnum);
            end
            ST_RFIX: begin
                mul_ctl.load    = 1'b1;
                mul_ctl.add_rnd = 1'b1;
                mul_a           = MA'(lmag);
                mul_b           = MB'(lnum);
            end
            ST_RDIV, ST_LDIV: begin
                mul_ctl.load = 1'b1;
                mul_a        = MA'(prod_q[NW-1:0]);
                mul_b        = RECIP;
            end
            default: begin
                mul_ctl = '0;
            end
        endcase
    end

    jddm_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .aclk (aclk),
        .ctl  (mul_ctl),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod_q)
    );

    // Sequencer, configuration, trim state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            deadband_reg     <= DEADBAND_RST;
            drive_limit_reg  <= DRIVE_LIMIT_RST;
            balance_step_reg <= BAL_STEP_RST;
            balance_reg      <= PCT_W'(BAL_CENTER);
            latch_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // Take configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_DEADBAND:     deadband_reg     <= cfg_wdata;
                    CFG_DRIVE_LIMIT:  drive_limit_reg  <= cfg_wdata;
                    CFG_BALANCE_STEP: balance_step_reg <= cfg_wdata[STEP_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once transferred, unless the next one loads now
            if (m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        ax_reg      <= stick_mag(sx);
                        ay_reg      <= stick_mag(sy);
                        xneg_reg    <= !sx[STICK_W-1] && (sx != '0);
                        yneg_reg    <= !sy[STICK_W-1] && (sy != '0);
                        dpad_reg    <= s_dpad_bits;
                        balance_reg <= balance_next;
                        latch_reg   <= latch_next;
                        state_reg   <= ST_SQX;
                    end
                end
                ST_SQX: state_reg <= ST_DLX;
                ST_DLX: state_reg <= ST_AXX;
                ST_AXX: begin
                    xq_reg    <= q_cur;
                    xdb_reg   <= db_cur;
                    state_reg <= ST_DLY;
                end
                ST_DLY: state_reg <= ST_AXY;
                ST_AXY: begin
                    xv_reg    <= xv_comb;
                    yv_reg    <= yv_comb;
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    rcmd_reg  <= clamp_cmd(rsum);
                    lcmd_reg  <= clamp_cmd(lsum);
                    state_reg <= ST_RMUL;
                end
                ST_RMUL: state_reg <= ST_RDIV;
                ST_RDIV: begin
                    n_reg     <= prod_q[NW-1:0];
                    state_reg <= ST_RFIX;
                end
                ST_RFIX: begin
                    rduty_reg <= duty_out;
                    state_reg <= ST_LDIV;
                end
                ST_LDIV: begin
                    n_reg     <= prod_q[NW-1:0];
                    state_reg <= ST_LFIX;
                end
                ST_LFIX: begin
                    lduty_reg <= duty_out;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // Advance only when the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_right_forward_reg <= !rcmd_reg[CW-1];
                        m_right_reverse_reg <= rcmd_reg[CW-1];
                        m_right_duty_reg    <= rduty_reg;
                        m_left_forward_reg  <= !lcmd_reg[CW-1];
                        m_left_reverse_reg  <= lcmd_reg[CW-1];
                        m_left_duty_reg     <= lduty_reg;
                        m_balance_now_reg   <= balance_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_right_forward = m_right_forward_reg;
    assign m_right_reverse = m_right_reverse_reg;
    assign m_right_duty    = m_right_duty_reg;
    assign m_left_forward  = m_left_forward_reg;
    assign m_left_reverse  = m_left_reverse_reg;
    assign m_left_duty     = m_left_duty_reg;
    assign m_balance_now   = m_balance_now_reg;

endmodule
